FILE: hw/rtl/lct_pkg.sv
// lct_pkg: shared constants for the lru connection table
// command codes, field widths and the default table depth; no dependencies

package lct_pkg;

    localparam int unsigned DEF_ENTRIES = 16;

    localparam int unsigned CMD_W    = 2;
    localparam int unsigned ADDR_W   = 32;
    localparam int unsigned HANDLE_W = 16;
    localparam int unsigned SLOT_W   = 4;
    localparam int unsigned TIME_W   = 32;

    typedef enum logic [CMD_W-1:0] {
        CMD_LOOKUP = 2'd0,
        CMD_INSERT = 2'd1,
        CMD_TICK   = 2'd2,
        CMD_NOP    = 2'd3
    } cmd_t;

endpackage

FILE: hw/rtl/lru_connection_table.sv
// lru_connection_table: fully associative address-to-handle table, lru replacement
// entry data lives in synchronous memories walked one entry per cycle; uses lct_pkg
//
// usage:
//   a transaction is taken at a rising edge with start high and busy low; command,
//   address and handle are sampled there. busy stays high while the table is walked.
//   each transaction gives one result: done is high for exactly one cycle with hit,
//   found_handle, slot, evicted and evicted_handle valid in that same cycle. the
//   receiver cannot stall, so the result must be taken when done is high.
// sequencing:
//   tick and the unused command: done is high in the cycle after the transaction is taken.
//   lookup and insert: the memories are read one entry per cycle with a registered
//   read; the walk covers all ENTRIES, then the finish state registers the results
//   and done. a hit or a free entry ends the walk early. the single memory read port
//   per field is why entries are read one at a time. start may be given again in the cycle done is high.
// reset:
//   rst_n clears all valid marks, the time counter and the control state at once;
//   no clearing pass is needed and the table is usable right after reset.

module lru_connection_table
    import lct_pkg::*;
#(
    parameter int unsigned ENTRIES = DEF_ENTRIES
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    output logic                busy,
    input  logic [CMD_W-1:0]    command,
    input  logic [ADDR_W-1:0]   address,
    input  logic [HANDLE_W-1:0] handle,
    output logic                done,
    output logic                hit,
    output logic [HANDLE_W-1:0] found_handle,
    output logic [SLOT_W-1:0]   slot,
    output logic                evicted,
    output logic [HANDLE_W-1:0] evicted_handle
);

    localparam int unsigned IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(ENTRIES - 1);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_FINISH
    } state_t;

    // entry storage
    logic [ADDR_W-1:0]   addr_mem [ENTRIES];
    logic [HANDLE_W-1:0] hdl_mem  [ENTRIES];
    logic [TIME_W-1:0]   lu_mem   [ENTRIES];

    logic [ADDR_W-1:0]   addr_rd_reg;
    logic [HANDLE_W-1:0] hdl_rd_reg;
    logic [TIME_W-1:0]   lu_rd_reg;

    state_t              state_reg;
    logic [ENTRIES-1:0]  valid_reg;
    logic [TIME_W-1:0]   time_reg;
    cmd_t                cmd_reg;
    logic [ADDR_W-1:0]   key_reg;
    logic [HANDLE_W-1:0] new_hdl_reg;
    logic [IDX_W-1:0]    rd_idx_reg;
    logic                issue_reg;
    logic [IDX_W-1:0]    eval_idx_reg;
    logic                eval_vld_reg;
    logic [IDX_W-1:0]    victim_reg;
    logic [HANDLE_W-1:0] victim_hdl_reg;
    logic [TIME_W-1:0]   max_age_reg;
    logic                match_reg;
    logic                free_reg;

    logic                done_reg;
    logic                hit_reg;
    logic [HANDLE_W-1:0] found_handle_reg;
    logic [SLOT_W-1:0]   slot_reg;
    logic                evicted_reg;
    logic [HANDLE_W-1:0] evicted_handle_reg;

    logic                accept;
    logic                ent_valid;
    logic [TIME_W-1:0]   age;
    logic                hit_now;
    logic                free_now;
    logic                better_now;
    logic                last_now;
    logic                wr_all;
    logic                wr_lu;

    assign busy           = (state_reg != ST_IDLE);
    assign accept         = start && !busy;
    assign done           = done_reg;
    assign hit            = hit_reg;
    assign found_handle   = found_handle_reg;
    assign slot           = slot_reg;
    assign evicted        = evicted_reg;
    assign evicted_handle = evicted_handle_reg;

    always_comb
    begin
        ent_valid  = valid_reg[eval_idx_reg];
        age        = time_reg - lu_rd_reg;
        hit_now    = eval_vld_reg && (cmd_reg == CMD_LOOKUP) && ent_valid
                     && (addr_rd_reg == key_reg);
        free_now   = eval_vld_reg && (cmd_reg == CMD_INSERT) && !ent_valid;
        better_now = eval_vld_reg && (cmd_reg == CMD_INSERT) && ent_valid
                     && ((age > max_age_reg) || (eval_idx_reg == '0));
        last_now   = eval_vld_reg && (eval_idx_reg == LAST_IDX);
        wr_all     = (state_reg == ST_FINISH) && (cmd_reg == CMD_INSERT);
        wr_lu      = wr_all || ((state_reg == ST_FINISH) && match_reg);
    end

    // memory read and write ports
    always_ff @(posedge clk)
    begin
        addr_rd_reg <= addr_mem[rd_idx_reg];
        hdl_rd_reg  <= hdl_mem[rd_idx_reg];
        lu_rd_reg   <= lu_mem[rd_idx_reg];
        if (wr_all)
        begin
            addr_mem[victim_reg] <= key_reg;
            hdl_mem[victim_reg]  <= new_hdl_reg;
        end
        if (wr_lu)
        begin
            lu_mem[victim_reg] <= time_reg;
        end
    end

    // walk datapath
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            key_reg     <= address;
            new_hdl_reg <= handle;
            max_age_reg <= '0;
            victim_reg  <= '0;
            victim_hdl_reg <= '0;
        end
        else if (state_reg == ST_SCAN)
        begin
            if (hit_now || free_now)
            begin
                victim_reg     <= eval_idx_reg;
                victim_hdl_reg <= hdl_rd_reg;
            end
            else if (better_now)
            begin
                victim_reg     <= eval_idx_reg;
                victim_hdl_reg <= hdl_rd_reg;
                max_age_reg    <= age;
            end
        end
    end

    // control and registered results
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg          <= ST_IDLE;
            valid_reg          <= '0;
            time_reg           <= '0;
            cmd_reg            <= CMD_NOP;
            rd_idx_reg         <= '0;
            issue_reg          <= 1'b0;
            eval_idx_reg       <= '0;
            eval_vld_reg       <= 1'b0;
            match_reg          <= 1'b0;
            free_reg           <= 1'b0;
            done_reg           <= 1'b0;
            hit_reg            <= 1'b0;
            found_handle_reg   <= '0;
            slot_reg           <= '0;
            evicted_reg        <= 1'b0;
            evicted_handle_reg <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            case (state_reg)
                ST_IDLE:
                begin
                    if (accept)
                    begin
                        cmd_reg            <= cmd_t'(command);
                        rd_idx_reg         <= '0;
                        issue_reg          <= 1'b1;
                        eval_vld_reg       <= 1'b0;
                        match_reg          <= 1'b0;
                        free_reg           <= 1'b0;
                        hit_reg            <= 1'b0;
                        found_handle_reg   <= '0;
                        slot_reg           <= '0;
                        evicted_reg        <= 1'b0;
                        evicted_handle_reg <= '0;
                        if ((cmd_t'(command) == CMD_LOOKUP)
                            || (cmd_t'(command) == CMD_INSERT))
                        begin
                            state_reg <= ST_SCAN;
                        end
                        else
                        begin
                            done_reg <= 1'b1;
                            if (cmd_t'(command) == CMD_TICK)
                            begin
                                time_reg <= time_reg + 1'b1;
                            end
                        end
                    end
                end
                ST_SCAN:
                begin
                    eval_idx_reg <= rd_idx_reg;
                    eval_vld_reg <= issue_reg;
                    if (issue_reg)
                    begin
                        if (rd_idx_reg == LAST_IDX)
                        begin
                            issue_reg <= 1'b0;
                        end
                        else
                        begin
                            rd_idx_reg <= rd_idx_reg + 1'b1;
                        end
                    end
                    if (hit_now || free_now || last_now)
                    begin
                        issue_reg    <= 1'b0;
                        eval_vld_reg <= 1'b0;
                        match_reg    <= hit_now;
                        free_reg     <= free_now;
                        state_reg    <= ST_FINISH;
                    end
                end
                ST_FINISH:
                begin
                    done_reg  <= 1'b1;
                    state_reg <= ST_IDLE;
                    if (cmd_reg == CMD_INSERT)
                    begin
                        valid_reg[victim_reg] <= 1'b1;
                        slot_reg              <= SLOT_W'(victim_reg);
                        evicted_reg           <= !free_reg;
                        evicted_handle_reg    <= free_reg ? '0 : victim_hdl_reg;
                    end
                    else if (match_reg)
                    begin
                        hit_reg          <= 1'b1;
                        found_handle_reg <= victim_hdl_reg;
                        slot_reg         <= SLOT_W'(victim_reg);
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

endmodule

FILE: sim/lct_checker.sv
`timescale 1ns / 100ps
// lct_checker: watches the command and result channels of lru_connection_table,
// keeps its own copy of the table and compares every result in order; uses lct_pkg

module lct_checker
    import lct_pkg::*;
#(
    parameter int unsigned ENTRIES = DEF_ENTRIES
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    input  logic                busy,
    input  logic [CMD_W-1:0]    command,
    input  logic [ADDR_W-1:0]   address,
    input  logic [HANDLE_W-1:0] handle,
    input  logic                done,
    input  logic                hit,
    input  logic [HANDLE_W-1:0] found_handle,
    input  logic [SLOT_W-1:0]   slot,
    input  logic                evicted,
    input  logic [HANDLE_W-1:0] evicted_handle,
    output int unsigned         fail_count,
    output int unsigned         pending,
    output int unsigned         hit_count,
    output int unsigned         evict_count
);

    typedef struct packed {
        logic                hit;
        logic [HANDLE_W-1:0] found_handle;
        logic [SLOT_W-1:0]   slot;
        logic                evicted;
        logic [HANDLE_W-1:0] evicted_handle;
    } table_result_t;

    logic                entry_valid  [ENTRIES];
    logic [ADDR_W-1:0]   entry_addr   [ENTRIES];
    logic [HANDLE_W-1:0] entry_handle [ENTRIES];
    logic [TIME_W-1:0]   entry_stamp  [ENTRIES];
    logic [TIME_W-1:0]   clock_now;

    table_result_t expected_results[$];
    int unsigned   mismatches;
    int unsigned   results_seen;
    int unsigned   hits;
    int unsigned   evictions;

    function automatic table_result_t apply_transaction(cmd_t cmd, logic [ADDR_W-1:0] addr,
                                                        logic [HANDLE_W-1:0] hdl);
        table_result_t     r;
        int                i;
        int                victim;
        bit                matched;
        bit                free_found;
        logic [TIME_W-1:0] age;
        logic [TIME_W-1:0] oldest;
        r          = '0;
        victim     = 0;
        matched    = 1'b0;
        free_found = 1'b0;
        oldest     = '0;
        case (cmd)
            CMD_LOOKUP:
            begin
                for (i = 0; i < ENTRIES; i++)
                begin
                    if (!matched && entry_valid[i] && entry_addr[i] == addr)
                    begin
                        matched        = 1'b1;
                        entry_stamp[i] = clock_now;
                        r.hit          = 1'b1;
                        r.found_handle = entry_handle[i];
                        r.slot         = SLOT_W'(i);
                    end
                end
            end
            CMD_INSERT:
            begin
                for (i = 0; i < ENTRIES; i++)
                begin
                    if (!free_found)
                    begin
                        if (!entry_valid[i])
                        begin
                            victim     = i;
                            free_found = 1'b1;
                        end
                        else
                        begin
                            age = clock_now - entry_stamp[i];
                            if (age > oldest)
                            begin
                                oldest = age;
                                victim = i;
                            end
                        end
                    end
                end
                if (!free_found)
                begin
                    r.evicted        = 1'b1;
                    r.evicted_handle = entry_handle[victim];
                end
                entry_valid[victim]  = 1'b1;
                entry_addr[victim]   = addr;
                entry_handle[victim] = hdl;
                entry_stamp[victim]  = clock_now;
                r.slot               = SLOT_W'(victim);
            end
            CMD_TICK:
            begin
                clock_now = clock_now + 1'b1;
            end
            default:
            begin
            end
        endcase
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        table_result_t seen;
        table_result_t want;
        if (!rst_n)
        begin
            for (int i = 0; i < ENTRIES; i++)
                entry_valid[i] = 1'b0;
            clock_now = '0;
            expected_results.delete();
            mismatches   = 0;
            results_seen = 0;
            hits         = 0;
            evictions    = 0;
            fail_count  <= 0;
            pending     <= 0;
            hit_count   <= 0;
            evict_count <= 0;
        end
        else
        begin
            if (done)
            begin
                seen = '{hit, found_handle, slot, evicted, evicted_handle};
                results_seen++;
                if (expected_results.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("lct_checker: result %0d arrived with no transaction pending",
                                 results_seen);
                end
                else
                begin
                    want = expected_results.pop_front();
                    if (seen.hit !== want.hit || seen.found_handle !== want.found_handle ||
                        seen.slot !== want.slot || seen.evicted !== want.evicted ||
                        seen.evicted_handle !== want.evicted_handle)
                    begin
                        mismatches++;
                        if (mismatches <= 10)
                        begin
                            $display("lct_checker: result %0d mismatch", results_seen);
                            $display("  expected hit=%0b handle=%h slot=%0d evicted=%0b ev_handle=%h",
                                     want.hit, want.found_handle, want.slot,
                                     want.evicted, want.evicted_handle);
                            $display("  actual   hit=%0b handle=%h slot=%0d evicted=%0b ev_handle=%h",
                                     seen.hit, seen.found_handle, seen.slot,
                                     seen.evicted, seen.evicted_handle);
                        end
                    end
                    if (want.hit)
                        hits++;
                    if (want.evicted)
                        evictions++;
                end
            end
            if (start && !busy)
                expected_results.push_back(apply_transaction(cmd_t'(command), address, handle));
            fail_count  <= mismatches;
            pending     <= expected_results.size();
            hit_count   <= hits;
            evict_count <= evictions;
        end
    end

endmodule

FILE: sim/tb_top.sv
`timescale 1ns / 100ps
// tb_top: stimulus and verdict for lru_connection_table
// drives directed and random transactions with random gaps; checking is in lct_checker

module tb_top;
    import lct_pkg::*;

    localparam int unsigned ENTRIES      = DEF_ENTRIES;
    localparam int unsigned RANDOM_ITEMS = 1700;
    localparam int unsigned POOL_SIZE    = 24;
    localparam int unsigned CYCLE_LIMIT  = 600000;

    logic                clk;
    logic                rst_n;
    logic                start;
    logic                busy;
    logic [CMD_W-1:0]    command;
    logic [ADDR_W-1:0]   address;
    logic [HANDLE_W-1:0] handle;
    logic                done;
    logic                hit;
    logic [HANDLE_W-1:0] found_handle;
    logic [SLOT_W-1:0]   slot;
    logic                evicted;
    logic [HANDLE_W-1:0] evicted_handle;

    int unsigned fail_count;
    int unsigned pending;
    int unsigned hit_count;
    int unsigned evict_count;
    int unsigned cycle_count;
    int unsigned sent_per_cmd[4];

    logic [ADDR_W-1:0] addr_pool[POOL_SIZE];

    lru_connection_table #(.ENTRIES(ENTRIES)) DUT (
        .clk            (clk),
        .rst_n          (rst_n),
        .start          (start),
        .busy           (busy),
        .command        (command),
        .address        (address),
        .handle         (handle),
        .done           (done),
        .hit            (hit),
        .found_handle   (found_handle),
        .slot           (slot),
        .evicted        (evicted),
        .evicted_handle (evicted_handle)
    );

    lct_checker #(.ENTRIES(ENTRIES)) lct_check (
        .clk            (clk),
        .rst_n          (rst_n),
        .start          (start),
        .busy           (busy),
        .command        (command),
        .address        (address),
        .handle         (handle),
        .done           (done),
        .hit            (hit),
        .found_handle   (found_handle),
        .slot           (slot),
        .evicted        (evicted),
        .evicted_handle (evicted_handle),
        .fail_count     (fail_count),
        .pending        (pending),
        .hit_count      (hit_count),
        .evict_count    (evict_count)
    );

    initial
    begin
        clk = 1'b0;
    end

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("tb_top: FAIL");
            $finish;
        end
    end

    // gap cycles with start low, then hold start until the transaction is taken
    task automatic send_transaction(cmd_t cmd, logic [ADDR_W-1:0] addr,
                                    logic [HANDLE_W-1:0] hdl, int unsigned gap);
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        start   <= 1'b1;
        command <= cmd;
        address <= addr;
        handle  <= hdl;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        sent_per_cmd[cmd]++;
    endtask

    task automatic drain_results();
        start <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
    endtask

    function automatic logic [ADDR_W-1:0] lookup_address();
        int unsigned pick;
        pick = $urandom_range(0, 9);
        if (pick < 7)
            return addr_pool[$urandom_range(0, POOL_SIZE - 1)];
        else if (pick < 8)
            return addr_pool[$urandom_range(0, POOL_SIZE - 1)] ^ (32'h1 << $urandom_range(0, 31));
        else
            return $urandom;
    endfunction

    initial
    begin
        int unsigned       n;
        int unsigned       sel;
        int unsigned       gap;
        bit                burst;
        logic [ADDR_W-1:0] addr;
        cycle_count = 0;
        rst_n   = 1'b0;
        start   = 1'b0;
        command = CMD_NOP;
        address = '0;
        handle  = '0;
        burst   = 1'b0;
        for (int i = 0; i < 4; i++)
            sent_per_cmd[i] = 0;
        for (int i = 0; i < POOL_SIZE; i++)
            addr_pool[i] = $urandom;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        // directed: empty table, extremes, duplicate insert, fill and all-tie eviction
        send_transaction(CMD_LOOKUP, 32'h0000_0000, 16'h0000, 0);
        send_transaction(CMD_NOP,    32'hFFFF_FFFF, 16'hFFFF, 0);
        send_transaction(CMD_TICK,   32'h0000_0000, 16'h0000, 1);
        send_transaction(CMD_INSERT, 32'h0000_0000, 16'hFFFF, 0);
        send_transaction(CMD_INSERT, 32'hFFFF_FFFF, 16'h0000, 2);
        send_transaction(CMD_LOOKUP, 32'hFFFF_FFFF, 16'hFFFF, 0);
        send_transaction(CMD_LOOKUP, 32'h0000_0000, 16'h0000, 0);
        send_transaction(CMD_INSERT, 32'h0000_0000, 16'h1234, 3);
        send_transaction(CMD_LOOKUP, 32'h0000_0000, 16'h0000, 0);
        send_transaction(CMD_LOOKUP, 32'h1234_5678, 16'h0000, 0);
        for (int k = 0; k < ENTRIES - 3; k++)
            send_transaction(CMD_INSERT, 32'hA5A5_0000 + k, HANDLE_W'(k), k % 3);
        send_transaction(CMD_INSERT, 32'h5A5A_5A5A, 16'hAAAA, 0);
        send_transaction(CMD_LOOKUP, 32'h0000_0000, 16'h0000, 0);
        drain_results();

        for (n = 0; n < RANDOM_ITEMS; n++)
        begin
            if (n % 50 == 0)
                burst = ($urandom_range(0, 3) == 0);
            if (n == RANDOM_ITEMS / 2)
                drain_results();
            gap = burst ? 0 : $urandom_range(0, 11);
            sel = $urandom_range(0, 99);
            if (sel < 35)
                send_transaction(CMD_LOOKUP, lookup_address(), HANDLE_W'($urandom), gap);
            else if (sel < 70)
            begin
                if ($urandom_range(0, 9) < 6)
                    addr = addr_pool[$urandom_range(0, POOL_SIZE - 1)];
                else
                begin
                    addr = $urandom;
                    addr_pool[$urandom_range(0, POOL_SIZE - 1)] = addr;
                end
                send_transaction(CMD_INSERT, addr, HANDLE_W'($urandom), gap);
            end
            else if (sel < 95)
                send_transaction(CMD_TICK, $urandom, HANDLE_W'($urandom), gap);
            else
                send_transaction(CMD_NOP, $urandom, HANDLE_W'($urandom), gap);
        end

        drain_results();
        repeat (ENTRIES + 8) @(posedge clk);
        $display("tb_top: %0d lookups (%0d hits), %0d inserts (%0d evictions)",
                 sent_per_cmd[CMD_LOOKUP], hit_count, sent_per_cmd[CMD_INSERT], evict_count);
        $display("tb_top: %0d ticks, %0d nops, %0d mismatches over %0d cycles",
                 sent_per_cmd[CMD_TICK], sent_per_cmd[CMD_NOP], fail_count, cycle_count);
        if (fail_count == 0 && pending == 0)
            $display("tb_top: PASS");
        else
            $display("tb_top: FAIL");
        $finish;
    end

endmodule
